### src/psg_pkg.sv
// Shared constants and types for the tone and noise sound generator.
`default_nettype none

package psg_pkg;

    // Channel layout: three tone channels followed by the noise channel.
    localparam int unsigned NUM_CH    = 4;
    localparam int unsigned NUM_TONE  = 3;
    localparam logic [1:0]  NOISE_CH  = 2'd3;

    // Register field widths.
    localparam int unsigned ATTEN_W   = 4;
    localparam int unsigned PERIOD_W  = 10;
    localparam int unsigned LFSR_W    = 16;

    // Attenuation value that silences a channel and freezes its counter.
    localparam logic [ATTEN_W-1:0]  ATTEN_OFF = 4'hF;

    // Shift register value after reset and after a noise type change.
    localparam logic [LFSR_W-1:0]   LFSR_SEED = 16'h8000;

    // Base reload of the noise counter before the rate shift.
    localparam logic [PERIOD_W-1:0] NOISE_BASE = 10'd16;

    // Request opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [ATTEN_W-1:0]  t_atten;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [LFSR_W-1:0]   t_lfsr;

endpackage

`default_nettype wire

### src/psg_if.sv
// Request and result handshake interfaces of the sound generator.
`default_nettype none

interface psg_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] write_byte;

    modport source (output valid, output opcode, output write_byte, input ready);
    modport sink   (input valid, input opcode, input write_byte, output ready);
endinterface

interface psg_res_if;
    logic       valid;
    logic       ready;
    logic       tone0_bit;
    logic       tone1_bit;
    logic       tone2_bit;
    logic       noise_bit;
    logic [3:0] atten0;
    logic [3:0] atten1;
    logic [3:0] atten2;
    logic [3:0] atten3;
    logic       sound_changed;

    modport source (output valid, output tone0_bit, output tone1_bit, output tone2_bit,
                    output noise_bit, output atten0, output atten1, output atten2,
                    output atten3, output sound_changed, input ready);
    modport sink   (input valid, input tone0_bit, input tone1_bit, input tone2_bit,
                    input noise_bit, input atten0, input atten1, input atten2,
                    input atten3, input sound_changed, output ready);
endinterface

`default_nettype wire

### src/psg_tone_noise_generator.sv
// Four-channel tone and noise generator driven by tick and register write requests.
// A result is registered and becomes valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register lets a new request
// enter whenever the result register is empty or is being drained in that cycle.
// Reset: synchronous, active low; all attenuations go to 15 (off), dividers,
// counters and levels to 0, and the noise shift register to 0x8000.
`default_nettype none

module psg_tone_noise_generator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    psg_req_if.sink    i_req,
    psg_res_if.source  o_res
);

    // Latch byte state: which channel and which register data bytes go to.
    logic [1:0]               r_latch_ch,   n_latch_ch;
    logic                     r_latch_att,  n_latch_att;

    // Per-channel registers.
    psg_pkg::t_atten          r_atten  [psg_pkg::NUM_CH];
    psg_pkg::t_atten          n_atten  [psg_pkg::NUM_CH];
    psg_pkg::t_period         r_period [psg_pkg::NUM_TONE];
    psg_pkg::t_period         n_period [psg_pkg::NUM_TONE];
    logic [3:0]               r_low    [psg_pkg::NUM_TONE];
    logic [3:0]               n_low    [psg_pkg::NUM_TONE];
    psg_pkg::t_period         r_cd     [psg_pkg::NUM_CH];
    psg_pkg::t_period         n_cd     [psg_pkg::NUM_CH];
    logic [psg_pkg::NUM_CH-1:0] r_level, n_level;

    // Noise control.
    logic [1:0]               r_rate,       n_rate;
    logic                     r_mode,       n_mode;
    logic                     r_prior_mode, n_prior_mode;
    psg_pkg::t_lfsr           r_lfsr,       n_lfsr;

    // Result register.
    logic                     r_out_valid;
    logic [psg_pkg::NUM_CH-1:0] r_out_level;
    psg_pkg::t_atten          r_out_atten [psg_pkg::NUM_CH];
    logic                     r_out_changed;

    logic                     w_accept;
    logic                     w_changed;

    // The result register frees up either when empty or when the sink takes it now,
    // so requests flow one per cycle as long as results are drained.
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Next-state logic for one request: either a tick of all four channels in
    // parallel or a single register byte write.
    always_comb begin
        logic                 latch;
        logic [1:0]           ch;
        logic                 is_att;
        psg_pkg::t_period     new_period;
        logic [1:0]           new_rate;
        logic                 new_mode;
        logic                 fb;

        n_latch_ch   = r_latch_ch;
        n_latch_att  = r_latch_att;
        n_atten      = r_atten;
        n_period     = r_period;
        n_low        = r_low;
        n_cd         = r_cd;
        n_level      = r_level;
        n_rate       = r_rate;
        n_mode       = r_mode;
        n_prior_mode = r_prior_mode;
        n_lfsr       = r_lfsr;
        w_changed    = 1'b0;

        latch      = i_req.write_byte[7];
        ch         = latch ? i_req.write_byte[6:5] : r_latch_ch;
        is_att     = latch ? i_req.write_byte[4]   : r_latch_att;
        new_period = {i_req.write_byte[5:0], r_low[ch]};
        new_rate   = i_req.write_byte[1:0];
        new_mode   = i_req.write_byte[2];
        fb         = r_mode ? (r_lfsr[0] ^ r_lfsr[3]) : r_lfsr[0];

        if (w_accept) begin
            if (i_req.opcode == psg_pkg::OP_TICK) begin
                // Tone channels: a divider below 2 holds the output high.
                for (int i = 0; i < psg_pkg::NUM_TONE; i++) begin
                    if (r_atten[i] != psg_pkg::ATTEN_OFF) begin
                        if (r_period[i] < psg_pkg::t_period'(2)) begin
                            n_level[i] = 1'b1;
                        end else if (r_cd[i] == '0) begin
                            n_cd[i]    = r_period[i] - psg_pkg::t_period'(1);
                            n_level[i] = ~r_level[i];
                        end else begin
                            n_cd[i]    = r_cd[i] - psg_pkg::t_period'(1);
                        end
                    end
                end

                // Noise channel: rate 3 borrows the divider of tone channel 2.
                if (r_atten[psg_pkg::NOISE_CH] != psg_pkg::ATTEN_OFF) begin
                    if (r_rate == 2'd3 && r_period[2] < psg_pkg::t_period'(2)) begin
                        n_level[psg_pkg::NOISE_CH] = 1'b1;
                    end else if (r_cd[psg_pkg::NOISE_CH] != '0) begin
                        n_cd[psg_pkg::NOISE_CH] =
                            r_cd[psg_pkg::NOISE_CH] - psg_pkg::t_period'(1);
                    end else begin
                        if (r_rate == 2'd3) begin
                            n_cd[psg_pkg::NOISE_CH] = r_period[2] - psg_pkg::t_period'(1);
                        end else begin
                            n_cd[psg_pkg::NOISE_CH] =
                                (psg_pkg::NOISE_BASE << r_rate) - psg_pkg::t_period'(1);
                        end
                        // A change of noise type restarts the sequence from the seed.
                        if (r_prior_mode != r_mode) begin
                            n_lfsr       = psg_pkg::LFSR_SEED;
                            n_prior_mode = r_mode;
                        end else begin
                            n_lfsr = {fb, r_lfsr[psg_pkg::LFSR_W-1:1]};
                        end
                        n_level[psg_pkg::NOISE_CH] = n_lfsr[0];
                    end
                end
            end else begin
                if (latch) begin
                    n_latch_ch  = ch;
                    n_latch_att = is_att;
                end

                if (is_att) begin
                    if (i_req.write_byte[3:0] != r_atten[ch]) begin
                        n_atten[ch] = i_req.write_byte[3:0];
                        w_changed   = 1'b1;
                    end
                end else if (ch != psg_pkg::NOISE_CH) begin
                    // A latch byte only stages the low nibble; the data byte commits
                    // the whole divider.
                    if (latch) begin
                        n_low[ch] = i_req.write_byte[3:0];
                    end else if (new_period != r_period[ch]) begin
                        n_period[ch] = new_period;
                        w_changed    = 1'b1;
                    end
                end else begin
                    if (new_rate != r_rate || new_mode != r_mode) begin
                        n_rate    = new_rate;
                        n_mode    = new_mode;
                        w_changed = 1'b1;
                    end
                end
            end
        end
    end

    // Generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_ch   <= '0;
            r_latch_att  <= 1'b0;
            for (int i = 0; i < psg_pkg::NUM_CH; i++) begin
                r_atten[i] <= psg_pkg::ATTEN_OFF;
                r_cd[i]    <= '0;
            end
            for (int i = 0; i < psg_pkg::NUM_TONE; i++) begin
                r_period[i] <= '0;
                r_low[i]    <= '0;
            end
            r_level      <= '0;
            r_rate       <= '0;
            r_mode       <= 1'b0;
            r_prior_mode <= 1'b0;
            r_lfsr       <= psg_pkg::LFSR_SEED;
        end else begin
            r_latch_ch   <= n_latch_ch;
            r_latch_att  <= n_latch_att;
            r_atten      <= n_atten;
            r_cd         <= n_cd;
            r_period     <= n_period;
            r_low        <= n_low;
            r_level      <= n_level;
            r_rate       <= n_rate;
            r_mode       <= n_mode;
            r_prior_mode <= n_prior_mode;
            r_lfsr       <= n_lfsr;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload captures the state as it stands after the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_level   <= n_level;
            r_out_atten   <= n_atten;
            r_out_changed <= w_changed;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.tone0_bit     = r_out_level[0];
    assign o_res.tone1_bit     = r_out_level[1];
    assign o_res.tone2_bit     = r_out_level[2];
    assign o_res.noise_bit     = r_out_level[3];
    assign o_res.atten0        = r_out_atten[0];
    assign o_res.atten1        = r_out_atten[1];
    assign o_res.atten2        = r_out_atten[2];
    assign o_res.atten3        = r_out_atten[3];
    assign o_res.sound_changed = r_out_changed;

endmodule

`default_nettype wire

### tb/psg_tone_noise_generator_test.sv
// Self-checking testbench for the tone and noise generator with a behavioral predictor.
module psg_tone_noise_generator_test;

    import psg_pkg::*;

    // The total number of requests is about 26 directed ones plus about 650 random ones.
    localparam int TOTAL_REQS     = 676;
    // The watchdog limit covers the longest sender gap and receiver stall many times over.
    localparam int WATCHDOG_LIMIT = 2000;
    // In this noise rate the noise counter reloads from the divider of tone channel 2.
    localparam logic [1:0] RATE_FROM_TONE2 = 2'd3;
    // A register byte with this bit set is a latch byte, otherwise it is a data byte.
    localparam int LATCH_BIT      = 7;

    // One request as the sender queues it.
    typedef struct packed {
        logic       opcode;
        logic [7:0] write_byte;
    } sound_req_t;

    // One result: the four channel levels, the four attenuations and the change flag.
    typedef struct packed {
        logic   tone0_bit;
        logic   tone1_bit;
        logic   tone2_bit;
        logic   noise_bit;
        t_atten atten0;
        t_atten atten1;
        t_atten atten2;
        t_atten atten3;
        logic   sound_changed;
    } sound_out_t;

    logic i_clk;
    logic i_rst_n;

    psg_req_if req_if();
    psg_res_if res_if();

    psg_tone_noise_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Requests waiting to be driven, and results the predictor has worked out but not yet seen.
    sound_req_t pending_reqs[$];
    sound_out_t expected_sound[$];

    // The testbench's own copy of the generator state.
    logic [1:0] latch_ch_m;
    logic       latch_att_m;
    t_atten     atten_m[NUM_CH];
    t_period    period_m[NUM_TONE];
    logic [3:0] low_nibble_m[NUM_TONE];
    t_period    count_m[NUM_CH];
    logic       level_m[NUM_CH];
    logic [1:0] noise_rate_m;
    logic       white_m;
    logic       white_prev_m;
    t_lfsr      lfsr_m;

    // Handshake bookkeeping for the driver, the receiver and the monitor.
    logic req_taken   = 1'b0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   calm_cycles = 0;
    int   idle_cycles = 0;

    // Coverage tallies and error count for the summary.
    int tick_count     = 0;
    int write_count    = 0;
    int result_count   = 0;
    int changed_count  = 0;
    int tone_toggles   = 0;
    int noise_shifts   = 0;
    int reseed_count   = 0;
    int mismatch_count = 0;

    // Free-running clock with a period of 10 time units.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Puts the predicted state into its reset condition.
    task automatic reset_sound_model();
        int i;
        latch_ch_m   = 2'd0;
        latch_att_m  = 1'b0;
        for (i = 0; i < NUM_CH; i++) begin
            atten_m[i] = ATTEN_OFF;
            count_m[i] = '0;
            level_m[i] = 1'b0;
        end
        for (i = 0; i < NUM_TONE; i++) begin
            period_m[i]     = '0;
            low_nibble_m[i] = 4'd0;
        end
        noise_rate_m = 2'd0;
        white_m      = 1'b0;
        white_prev_m = 1'b0;
        lfsr_m       = LFSR_SEED;
    endtask

    // Applies one accepted request to the predicted state and returns the result it must produce.
    task automatic predict_sound(input logic op, input logic [7:0] wb, output sound_out_t res);
        int         i;
        logic [1:0] ch;
        logic       changed;
        t_period    new_period;
        changed = 1'b0;
        if (op == OP_TICK) begin
            // Tone channels: a divider below 2 pins the level high, otherwise the
            // counter runs down and the level flips each time it expires.
            for (i = 0; i < NUM_TONE; i++) begin
                if (atten_m[i] != ATTEN_OFF) begin
                    if (period_m[i] < 2) begin
                        level_m[i] = 1'b1;
                    end else if (count_m[i] == 0) begin
                        count_m[i] = period_m[i] - 1'b1;
                        level_m[i] = ~level_m[i];
                        tone_toggles++;
                    end else begin
                        count_m[i] = count_m[i] - 1'b1;
                    end
                end
            end
            // Noise channel: it follows tone channel 2 in the last rate, and otherwise
            // reloads from a fixed base shifted by the rate.
            if (atten_m[NOISE_CH] != ATTEN_OFF) begin
                if (noise_rate_m == RATE_FROM_TONE2 && period_m[2] < 2) begin
                    level_m[NOISE_CH] = 1'b1;
                end else if (count_m[NOISE_CH] != 0) begin
                    count_m[NOISE_CH] = count_m[NOISE_CH] - 1'b1;
                end else begin
                    if (noise_rate_m == RATE_FROM_TONE2)
                        count_m[NOISE_CH] = period_m[2] - 1'b1;
                    else
                        count_m[NOISE_CH] = (NOISE_BASE << noise_rate_m) - 1'b1;
                    // A change of noise type takes effect as a reseed on the next shift.
                    if (white_prev_m != white_m) begin
                        lfsr_m       = LFSR_SEED;
                        white_prev_m = white_m;
                        reseed_count++;
                    end else if (white_m) begin
                        lfsr_m = {lfsr_m[0] ^ lfsr_m[3], lfsr_m[LFSR_W-1:1]};
                    end else begin
                        lfsr_m = {lfsr_m[0], lfsr_m[LFSR_W-1:1]};
                    end
                    level_m[NOISE_CH] = lfsr_m[0];
                    noise_shifts++;
                end
            end
        end else begin
            // A latch byte selects channel and register; a data byte reuses the last selection.
            if (wb[LATCH_BIT]) begin
                latch_ch_m  = wb[6:5];
                latch_att_m = wb[4];
            end
            ch = latch_ch_m;
            if (latch_att_m) begin
                if (wb[3:0] != atten_m[ch]) begin
                    atten_m[ch] = wb[3:0];
                    changed     = 1'b1;
                end
            end else if (ch != NOISE_CH) begin
                if (wb[LATCH_BIT]) begin
                    low_nibble_m[ch] = wb[3:0];
                end else begin
                    // Only six data bits reach the divider, so bit 6 is dropped.
                    new_period = {wb[5:0], low_nibble_m[ch]};
                    if (new_period != period_m[ch]) begin
                        period_m[ch] = new_period;
                        changed      = 1'b1;
                    end
                end
            end else begin
                if (wb[1:0] != noise_rate_m || wb[2] != white_m) begin
                    noise_rate_m = wb[1:0];
                    white_m      = wb[2];
                    changed      = 1'b1;
                end
            end
        end
        res.tone0_bit     = level_m[0];
        res.tone1_bit     = level_m[1];
        res.tone2_bit     = level_m[2];
        res.noise_bit     = level_m[NOISE_CH];
        res.atten0        = atten_m[0];
        res.atten1        = atten_m[1];
        res.atten2        = atten_m[2];
        res.atten3        = atten_m[NOISE_CH];
        res.sound_changed = changed;
    endtask

    function automatic logic [7:0] latch_byte(input logic [1:0] ch, input logic is_att,
                                              input logic [3:0] low);
        return {1'b1, ch, is_att, low};
    endfunction

    // Data byte for a tone divider: mostly tiny dividers so that channels toggle often,
    // now and then the full range. Bit 6 is random since the design must mask it.
    function automatic logic [7:0] period_data();
        logic [7:0] b;
        b = 8'($urandom_range(0, 127));
        if ($urandom_range(0, 9) < 8)
            b[5:1] = 5'd0;
        return b;
    endfunction

    // Attenuation that is mostly audible and sometimes off.
    function automatic t_atten pick_atten();
        if ($urandom_range(0, 9) == 0)
            return ATTEN_OFF;
        return t_atten'($urandom_range(0, 14));
    endfunction

    // Idle length for either side: mostly none or short, a few long, none during a calm stretch.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (calm_cycles > 0 || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic put_tick(input logic [7:0] junk);
        sound_req_t r;
        r.opcode     = OP_TICK;
        r.write_byte = junk;
        pending_reqs.push_back(r);
    endtask

    task automatic put_write(input logic [7:0] wb);
        sound_req_t r;
        r.opcode     = OP_WRITE;
        r.write_byte = wb;
        pending_reqs.push_back(r);
    endtask

    // Compares one field and reports it if it differs.
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Request driver: it changes the request channel on the falling edge and holds a
    // request until it has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_taken) begin
            // The request stays on the bus until the design takes it.
        end else if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            req_if.valid      <= 1'b1;
            req_if.opcode     <= pending_reqs[0].opcode;
            req_if.write_byte <= pending_reqs[0].write_byte;
            pending_reqs.pop_front();
            send_gap <= pick_idle();
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls of ready, with occasional calm stretches in which
    // neither side idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (calm_cycles > 0) begin
            calm_cycles  <= calm_cycles - 1;
            res_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 3)
                calm_cycles <= $urandom_range(40, 150);
            else
                stall_left <= pick_idle();
        end
    end

    // Monitor: at each rising edge it checks a delivered result against the oldest
    // expectation, then predicts the result of a request taken at the same edge.
    always @(posedge i_clk) begin
        sound_out_t want;
        sound_out_t predicted;
        logic       req_fire;
        logic       res_fire;
        req_fire = i_rst_n && req_if.valid && req_if.ready;
        res_fire = i_rst_n && res_if.valid && res_if.ready;
        req_taken <= req_fire;

        if (res_fire) begin
            result_count++;
            if (expected_sound.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %0h", $time,
                         {res_if.tone0_bit, res_if.tone1_bit, res_if.tone2_bit,
                          res_if.noise_bit, res_if.atten0, res_if.atten1, res_if.atten2,
                          res_if.atten3, res_if.sound_changed});
            end else begin
                want = expected_sound.pop_front();
                check_field("tone0_bit", want.tone0_bit, res_if.tone0_bit);
                check_field("tone1_bit", want.tone1_bit, res_if.tone1_bit);
                check_field("tone2_bit", want.tone2_bit, res_if.tone2_bit);
                check_field("noise_bit", want.noise_bit, res_if.noise_bit);
                check_field("atten0", want.atten0, res_if.atten0);
                check_field("atten1", want.atten1, res_if.atten1);
                check_field("atten2", want.atten2, res_if.atten2);
                check_field("atten3", want.atten3, res_if.atten3);
                check_field("sound_changed", want.sound_changed, res_if.sound_changed);
            end
        end

        if (req_fire) begin
            if (req_if.opcode == OP_TICK)
                tick_count++;
            else
                write_count++;
            predict_sound(req_if.opcode, req_if.write_byte, predicted);
            if (predicted.sound_changed)
                changed_count++;
            expected_sound.push_back(predicted);
        end

        // Watchdog: the run is stuck when nothing moves on either channel for too long.
        if (req_fire || res_fire || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results still expected",
                     $time, idle_cycles, expected_sound.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        int         pick;
        int         burst;
        logic [1:0] ch;

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.opcode     = OP_TICK;
        req_if.write_byte = 8'd0;
        res_if.ready      = 1'b0;
        reset_sound_model();

        // Directed part. Right after reset everything is muted, so a tick changes
        // nothing, and the byte that comes with a tick must be ignored.
        put_tick(8'hFF);
        put_write(latch_byte(2'd0, 1'b1, 4'd0));       // unmute tone 0
        put_write(latch_byte(2'd0, 1'b1, 4'd0));       // same value again: no change
        put_write(latch_byte(2'd0, 1'b0, 4'hF));       // low nibble only, no change
        put_write(8'h3F);                              // largest divider
        put_write(8'h7F);                              // bit 6 masked: same divider
        put_tick(8'h00);
        put_tick(8'hAA);
        put_write(latch_byte(2'd1, 1'b0, 4'd1));
        put_write(8'h00);                              // divider 1 holds the level high
        put_write(latch_byte(2'd1, 1'b1, 4'd0));
        put_tick(8'h55);
        put_write(latch_byte(2'd2, 1'b0, 4'd2));
        put_write(8'h00);                              // smallest divider that toggles
        put_write(latch_byte(2'd2, 1'b1, 4'd0));
        put_write(latch_byte(NOISE_CH, 1'b0, 4'h7));   // white noise clocked from tone 2
        put_write(latch_byte(NOISE_CH, 1'b1, 4'd0));
        put_tick(8'h00);
        put_tick(8'h00);
        put_tick(8'h00);
        put_write(8'h0F);                              // data byte mutes the noise channel
        put_tick(8'h00);
        put_write(latch_byte(NOISE_CH, 1'b0, 4'h0));   // periodic noise, fastest fixed rate
        put_write(8'h04);                              // data byte switches back to white
        put_write(latch_byte(2'd0, 1'b0, 4'h0));
        put_write(8'h00);                              // divider 0 on tone 0

        // Random part: mostly ticks in bursts so the counters run, mixed with
        // well-formed latch and data pairs, lone data bytes and arbitrary bytes.
        while (pending_reqs.size() < TOTAL_REQS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                burst = $urandom_range(1, 12);
                repeat (burst) put_tick(8'($urandom_range(0, 255)));
            end else if (pick < 64) begin
                ch = 2'($urandom_range(0, 2));
                put_write(latch_byte(ch, 1'b0, 4'($urandom)));
                if ($urandom_range(0, 9) < 9)
                    put_write(period_data());
            end else if (pick < 78) begin
                ch = 2'($urandom_range(0, 3));
                put_write(latch_byte(ch, 1'b1, pick_atten()));
                if ($urandom_range(0, 3) == 0)
                    put_write({1'b0, 3'($urandom), pick_atten()});
            end else if (pick < 88) begin
                put_write(latch_byte(NOISE_CH, 1'b0, 4'($urandom)));
                if ($urandom_range(0, 2) == 0)
                    put_write({1'b0, 7'($urandom)});
            end else if (pick < 94) begin
                put_write(period_data());
            end else begin
                put_write(8'($urandom_range(0, 255)));
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has been taken and every result has arrived,
        // then a few more cycles for any result that should not come.
        while (pending_reqs.size() != 0 || req_if.valid || expected_sound.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Covered %0d ticks and %0d register writes, %0d of which changed the sound.",
                 tick_count, write_count, changed_count);
        $display("Checked %0d results; %0d tone toggles, %0d noise shifts, %0d noise reseeds.",
                 result_count, tone_toggles, noise_shifts, reseed_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches in total", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
